// ===== design/csm_pkg.sv =====
package csm_pkg;

	// default sizes
	localparam int MAX_ROWS_DEF = 64;
	localparam int MAX_COLS_DEF = 256;
	localparam int CAPACITY_DEF = 256;

	// fixed field widths
	localparam int ROW_W = 6;
	localparam int COL_W = 8;
	localparam int VAL_W = 32;
	localparam int RIU_W = 7;

	localparam logic [RIU_W-1:0] ROWS_RESET = 7'd64;

	typedef enum logic [1:0] {
		STAT_DONE  = 2'd0,
		STAT_ZERO  = 2'd1,
		STAT_FULL  = 2'd2,
		STAT_RANGE = 2'd3
	} status_t;

	typedef enum logic {
		OP_INSERT = 1'b0,
		OP_READ   = 1'b1
	} op_t;

	// one stored nonzero entry
	typedef struct packed {
		logic             valid;
		logic [ROW_W-1:0] row;
		logic [COL_W-1:0] col;
		logic [VAL_W-1:0] value;
	} entry_t;

	// broadcast from the controller to every cell
	typedef struct packed {
		logic             insert_en;
		logic [ROW_W-1:0] row;
		logic [COL_W-1:0] col;
		logic [VAL_W-1:0] value;
	} cell_cmd_t;

endpackage

// ===== design/csm_cell.sv =====
module csm_cell import csm_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  cell_cmd_t        cmd,
	input  entry_t           prev_entry,
	input  logic             prev_ge,
	input  logic             prev_match,
	input  logic [VAL_W-1:0] prev_acc,
	output entry_t           entry,
	output logic             ge,
	output logic             match,
	output logic [VAL_W-1:0] acc
);

	logic             valid_q;
	logic [ROW_W-1:0] row_q;
	logic [COL_W-1:0] col_q;
	logic [VAL_W-1:0] value_q;
	logic [VAL_W-1:0] acc_q;
	logic             take_prev;
	logic             take_new;

	// cell sits at or after the insert point (empty cells always do)
	assign ge    = !valid_q || ({row_q, col_q} >= {cmd.row, cmd.col});
	assign match = valid_q && (row_q == cmd.row) && (col_q == cmd.col);

	// shift up from the neighbor, or take the new beat at the boundary
	assign take_prev = cmd.insert_en && prev_ge;
	assign take_new  = cmd.insert_en && ge && !prev_ge;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (take_prev) begin
			valid_q <= prev_entry.valid;
		end else if (take_new) begin
			valid_q <= 1'b1;
		end
	end

	// payload holds unless one of the two moves applies
	always_ff @(posedge clk) begin
		if (take_prev) begin
			row_q   <= prev_entry.row;
			col_q   <= prev_entry.col;
			value_q <= prev_entry.value;
		end else if (take_new) begin
			row_q   <= cmd.row;
			col_q   <= cmd.col;
			value_q <= cmd.value;
		end
	end

	// read wave: only the first matching cell of the run contributes
	always_ff @(posedge clk) begin
		acc_q <= prev_acc | ((match && !prev_match) ? value_q : '0);
	end

	assign entry = '{valid: valid_q, row: row_q, col: col_q, value: value_q};
	assign acc   = acc_q;

endmodule

// ===== design/csr_sparse_matrix_store.sv =====
// Sparse matrix store in compressed-row order, built as a chain of entry cells.
// Each cell holds one nonzero (row, column, value); the chain stays sorted by
// row, then column, with the newest of equal columns first.
// Input channel: in_valid/in_stall carry operation, row, col, value. A beat is
// taken only while the controller is idle; in_stall is high while one works.
// Output channel: out_valid/out_stall carry read_value and status, one result
// beat per input beat. The result sits in an output register, so the next
// input beat is taken while an earlier result still waits on out_stall.
// Insert and rejected accesses register their input beat, then their result; the
// shift of an insert happens in the same cycle in all cells. A read scans the
// chain: its result wave walks the chain one cell per cycle, and the result is
// registered once the wave has left the last cell.
// Configuration: rows_in_use at byte address 0 over the APB port; write it
// only while idle.
// Reset: all cells empty, rows_in_use = 64, no result pending.
module csr_sparse_matrix_store import csm_pkg::*; #(
	parameter int MAX_ROWS = MAX_ROWS_DEF,
	parameter int MAX_COLS = MAX_COLS_DEF,
	parameter int CAPACITY = CAPACITY_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	// configuration
	input  logic             psel,
	input  logic             penable,
	input  logic             pwrite,
	input  logic [2:0]       paddr,
	input  logic [31:0]      pwdata,
	output logic [31:0]      prdata,
	output logic             pready,
	// input channel
	input  logic             in_valid,
	output logic             in_stall,
	input  logic [0:0]       operation,
	input  logic [ROW_W-1:0] row,
	input  logic [COL_W-1:0] col,
	input  logic [VAL_W-1:0] value,
	// output channel
	output logic             out_valid,
	input  logic             out_stall,
	output logic [VAL_W-1:0] read_value,
	output logic [1:0]       status
);

	localparam int NW = $clog2(CAPACITY + 1);
	localparam int CW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam logic REG_ROWS_IN_USE = 1'b0;

	typedef enum logic [1:0] {
		S_IDLE,
		S_EXEC,
		S_SCAN
	} state_t;

	state_t           state_q;
	logic [RIU_W-1:0] rows_q;
	op_t              op_q;
	logic [ROW_W-1:0] row_q;
	logic [COL_W-1:0] col_q;
	logic [VAL_W-1:0] value_q;
	logic [NW-1:0]    count_q;
	logic [CW-1:0]    cnt_q;
	logic             out_valid_q;
	logic [VAL_W-1:0] read_value_q;
	status_t          status_q;

	logic             in_range;
	logic             full;
	logic             out_free;
	logic             insert_en;
	status_t          exec_status;
	cell_cmd_t        cmd;

	entry_t           ent     [CAPACITY];
	logic             ge_w    [CAPACITY];
	logic             match_w [CAPACITY];
	logic [VAL_W-1:0] acc_w   [CAPACITY];

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q <= ROWS_RESET;
		end else if (psel && penable && pwrite && (paddr[2] == REG_ROWS_IN_USE)) begin
			rows_q <= pwdata[RIU_W-1:0];
		end
	end

	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_ROWS_IN_USE) ? {{(32-RIU_W){1'b0}}, rows_q} : 32'd0;

	// request checks
	assign in_range = (int'(row_q) < MAX_ROWS) && ({1'b0, row_q} < rows_q)
			&& (int'(col_q) < MAX_COLS);
	assign full     = (count_q == NW'(CAPACITY));
	assign out_free = !out_valid_q || !out_stall;

	always_comb begin
		priority if (!in_range) begin
			exec_status = STAT_RANGE;
		end else if (op_q == OP_READ) begin
			exec_status = STAT_DONE;
		end else if (value_q == '0) begin
			exec_status = STAT_ZERO;
		end else if (full) begin
			exec_status = STAT_FULL;
		end else begin
			exec_status = STAT_DONE;
		end
	end

	assign insert_en = (state_q == S_EXEC) && out_free && (op_q == OP_INSERT)
			&& in_range && (value_q != '0) && !full;

	assign cmd = '{insert_en: insert_en, row: row_q, col: col_q, value: value_q};

	// cell chain
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		if (i == 0) begin : g_head
			csm_cell u_cell (
				.clk        (clk),
				.arst_n     (arst_n),
				.cmd        (cmd),
				.prev_entry ('0),
				.prev_ge    (1'b0),
				.prev_match (1'b0),
				.prev_acc   ('0),
				.entry      (ent[i]),
				.ge         (ge_w[i]),
				.match      (match_w[i]),
				.acc        (acc_w[i])
			);
		end else begin : g_body
			csm_cell u_cell (
				.clk        (clk),
				.arst_n     (arst_n),
				.cmd        (cmd),
				.prev_entry (ent[i-1]),
				.prev_ge    (ge_w[i-1]),
				.prev_match (match_w[i-1]),
				.prev_acc   (acc_w[i-1]),
				.entry      (ent[i]),
				.ge         (ge_w[i]),
				.match      (match_w[i]),
				.acc        (acc_w[i])
			);
		end
	end

	// controller
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			op_q         <= OP_INSERT;
			row_q        <= '0;
			col_q        <= '0;
			value_q      <= '0;
			count_q      <= '0;
			cnt_q        <= '0;
			out_valid_q  <= 1'b0;
			read_value_q <= '0;
			status_q     <= STAT_DONE;
		end else begin
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						op_q    <= op_t'(operation);
						row_q   <= row;
						col_q   <= col;
						value_q <= value;
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					if (in_range && (op_q == OP_READ)) begin
						cnt_q   <= '0;
						state_q <= S_SCAN;
					end else if (out_free) begin
						out_valid_q  <= 1'b1;
						read_value_q <= '0;
						status_q     <= exec_status;
						if (insert_en) begin
							count_q <= count_q + 1'b1;
						end
						state_q <= S_IDLE;
					end
				end
				S_SCAN: begin
					if (cnt_q == CW'(CAPACITY - 1)) begin
						if (out_free) begin
							out_valid_q  <= 1'b1;
							read_value_q <= acc_w[CAPACITY-1];
							status_q     <= STAT_DONE;
							state_q      <= S_IDLE;
						end
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign in_stall   = (state_q != S_IDLE);
	assign out_valid  = out_valid_q;
	assign read_value = read_value_q;
	assign status     = status_q;

`ifndef ASSERT_OFF
	// entry count tracks the occupied cells
	a_count_max: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= NW'(CAPACITY))
		else $error("entry count above capacity");

	a_tail_full: assert property (@(posedge clk) disable iff (!arst_n)
		ent[CAPACITY-1].valid == full)
		else $error("last cell occupancy disagrees with entry count");

	a_head_used: assert property (@(posedge clk) disable iff (!arst_n)
		ent[0].valid == (count_q != '0))
		else $error("first cell occupancy disagrees with entry count");

	a_insert_grows: assert property (@(posedge clk) disable iff (!arst_n)
		insert_en |=> (count_q == NW'($past(count_q) + 1'b1)))
		else $error("insert did not grow the entry count");
`endif

endmodule
